// ===== rtl/core/s256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 message hash.
`default_nettype none

package s256_pkg;

    typedef logic [7:0][31:0] t_hash;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLOCK,
        ST_PAD,
        ST_PAD_RUN,
        ST_DIGEST
    } t_state;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       init;
        logic [5:0] pos;
        logic [7:0] data;
    } t_ctl;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam t_hash HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/s256_compress.sv =====
// SHA-256 block window and compression unit running one round per cycle.
`default_nettype none

module s256_compress import s256_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_ctl  i_ctl,
    output logic       o_busy,
    output t_hash      o_hash
);

    t_hash             r_h;
    t_hash             r_v;
    logic [15:0][31:0] r_w;
    logic [5:0]        r_round;
    logic              r_busy;
    logic              r_fin;

    logic [31:0] big0, big1, choose, major, t1, t2, sig0, sig1, w_new;

    always_comb begin
        big1   = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        choose = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        big0   = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        major  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1     = r_v[7] + big1 + choose + round_k(r_round) + r_w[0];
        t2     = big0 + major;
        sig1   = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        sig0   = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_new  = sig1 + r_w[9] + sig0 + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_round <= '0;
            r_h     <= HASH_IV;
        end else begin
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_fin   <= 1'b0;
                r_round <= '0;
            end else if (r_busy) begin
                if (r_fin) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b0;
                end else begin
                    if (r_round == 6'd63) begin
                        r_fin <= 1'b1;
                    end
                    r_round <= r_round + 6'd1;
                end
            end
            if (i_ctl.init) begin
                r_h <= HASH_IV;
            end else if (r_busy && r_fin) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_v <= r_h;
        end else if (r_busy && !r_fin) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_ctl.load) begin
            r_w[i_ctl.pos[5:2]][{~i_ctl.pos[1:0], 3'b000} +: 8] <= i_ctl.data;
        end else if (r_busy && !r_fin) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_new;
        end
    end

    assign o_busy = r_busy;
    assign o_hash = r_h;

endmodule

`default_nettype wire

// ===== rtl/core/sha256_message_hash.sv =====
// Top level of the SHA-256 message hash: byte intake, padding sequencer and digest output.
// Each message byte is one input item. The item that completes a 64-byte block keeps
// the input stalled while the shared round unit runs the 64 rounds and folds the
// result into the chaining hash. An item with the end mark starts padding, written
// one byte per cycle up to the end of the block and followed by a compression wait,
// once more when the pad byte falls at position 56 or later. The digest then leaves
// as four 64-bit big-endian items, word 0 first, and the block is ready for a new message.
`default_nettype none

module sha256_message_hash import s256_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_end_of_message,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_digest_word,
    output logic [1:0]       o_word_index,
    output logic             o_last_word
);

    t_state      r_state;
    t_state      n_state;
    logic [5:0]  r_pos;
    logic [5:0]  n_pos;
    logic [63:0] r_count;
    logic [1:0]  r_idx;
    logic        r_eom;
    logic        r_first;
    logic        r_final;
    logic        in_acc;
    logic        out_acc;
    logic        busy;
    t_ctl        ctl;
    t_hash       hash;
    logic [7:0]  pad_data;

    s256_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_busy  (busy),
        .o_hash  (hash)
    );

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;
    assign n_pos   = r_pos + {5'd0, i_byte_present};

    always_comb begin
        if (r_first) begin
            pad_data = PAD_BYTE;
        end else if (r_final && (r_pos[5:3] == 3'b111)) begin
            pad_data = r_count[{~r_pos[2:0], 3'b000} +: 8];
        end else begin
            pad_data = 8'h00;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_byte_present && (r_pos == 6'd63)) begin
                        n_state = ST_BLOCK;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_BLOCK: begin
                if (!busy) begin
                    n_state = r_eom ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                if (r_pos == 6'd63) begin
                    n_state = ST_PAD_RUN;
                end
            end
            ST_PAD_RUN: begin
                if (!busy) begin
                    n_state = r_final ? ST_DIGEST : ST_PAD;
                end
            end
            ST_DIGEST: begin
                if (out_acc && (r_idx == 2'd3)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        ctl         = '0;
        ctl.pos     = r_pos;
        ctl.data    = i_data_byte;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_byte_present) begin
                    ctl.load  = 1'b1;
                    ctl.start = (r_pos == 6'd63);
                end
            end
            ST_PAD: begin
                ctl.load  = 1'b1;
                ctl.data  = pad_data;
                ctl.start = (r_pos == 6'd63);
            end
            ST_DIGEST: begin
                o_out_valid = 1'b1;
                ctl.init    = i_out_ready && (r_idx == 2'd3);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_eom   <= 1'b0;
            r_first <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_eom <= i_end_of_message;
                        if (i_byte_present) begin
                            r_pos   <= n_pos;
                            r_count <= r_count + 64'd8;
                        end
                        if (i_end_of_message) begin
                            r_first <= 1'b1;
                            r_final <= (n_pos[5:3] != 3'b111);
                        end
                    end
                end
                ST_PAD: begin
                    r_first <= 1'b0;
                    r_pos   <= r_pos + 6'd1;
                end
                ST_PAD_RUN: begin
                    if (!busy) begin
                        r_final <= 1'b1;
                    end
                end
                ST_DIGEST: begin
                    if (out_acc) begin
                        r_idx <= r_idx + 2'd1;
                        if (r_idx == 2'd3) begin
                            r_pos   <= '0;
                            r_count <= '0;
                            r_eom   <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    assign o_digest_word = {hash[{r_idx, 1'b0}], hash[{r_idx, 1'b1}]};
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 2'd3);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the SHA-256 message hash: byte items in, digest words out.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 300;
    localparam int SHOWN_ERRORS   = 10;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;

    localparam logic [0:7][31:0] START_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [63:0] word;
        logic [1:0]  idx;
        logic        last;
    } digest_word_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         eom;
        logic         pinned;
        logic [255:0] digest;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_byte_present;
    logic        i_end_of_message;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_last_word;

    sha256_message_hash uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    // Mirror of the hashing state.
    logic [31:0] hash_words [8];
    logic [7:0]  block_bytes [64];
    logic [5:0]  fill_level;
    logic [63:0] bit_length;

    digest_word_t digest_words_due [$];
    digest_word_t want;
    stim_row_t    dir_tab [16];

    int send_idle = 0;
    int recv_idle = 0;
    int items_offered = 0;
    int messages_closed = 0;
    int words_checked = 0;
    int mismatches = 0;
    int idle_run = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    logic hold_go;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    function automatic void restart_hash();
        int k;
        for (k = 0; k < 8; k++) hash_words[k] = START_HASH[k];
        for (k = 0; k < 64; k++) block_bytes[k] = 8'h00;
        fill_level = 6'd0;
        bit_length = 64'd0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        int t;
        for (t = 0; t < 16; t++) begin
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
        end
        for (t = 16; t < 64; t++) begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
        e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
        for (t = 0; t < 64; t++) begin
            s1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
            t1 = h + s1 + ((e & f) ^ (~e & g)) + ROUND_CONST[t] + w[t];
            s0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
            t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
        hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
    endfunction

    // Absorbs one item and returns 1 with the digest when it closes a message.
    function automatic logic absorb_byte(input logic [7:0] data, input logic present,
                                         input logic eom, output logic [255:0] digest);
        int k;
        digest = '0;
        if (present) begin
            block_bytes[fill_level] = data;
            fill_level = fill_level + 6'd1;
            bit_length = bit_length + 64'd8;
            if (fill_level == 6'd0) compress_block();
        end
        if (!eom) return 1'b0;
        block_bytes[fill_level] = PAD_MARK;
        for (k = fill_level + 1; k < 64; k++) block_bytes[k] = 8'h00;
        if (fill_level >= 6'd56) begin
            compress_block();
            for (k = 0; k < 56; k++) block_bytes[k] = 8'h00;
        end
        for (k = 0; k < 8; k++) block_bytes[56+k] = bit_length[63-8*k -: 8];
        compress_block();
        for (k = 0; k < 8; k++) digest[255-32*k -: 32] = hash_words[k];
        restart_hash();
        return 1'b1;
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) $display("mismatch: %s", msg);
    endfunction

    task automatic offer_item(input logic [7:0] data, input logic present, input logic eom,
                              input logic pinned, input logic [255:0] pinned_digest);
        logic [255:0] digest;
        logic taken;
        digest_word_t rec;
        int k;
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_data_byte      <= data;
        i_byte_present   <= present;
        i_end_of_message <= eom;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = o_in_ready;
        end
        items_offered++;
        if (absorb_byte(data, present, eom, digest)) begin
            messages_closed++;
            if (pinned) digest = pinned_digest;
            for (k = 0; k < 4; k++) begin
                rec.word = digest[255-64*k -: 64];
                rec.idx  = 2'(k);
                rec.last = (k == 3);
                digest_words_due.push_back(rec);
            end
        end
    endtask

    // Sends a message of len bytes; with tail set, the last byte rides on the end item.
    task automatic send_message(input int len, input logic tail);
        int b;
        for (b = 0; b < len - tail; b++) begin
            if ($urandom_range(0, 99) < 8) offer_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
            offer_item(8'($urandom), 1'b1, 1'b0, 1'b0, '0);
        end
        offer_item(8'($urandom), tail, 1'b1, 1'b0, '0);
    endtask

    task automatic send_random_until(input int goal);
        int len;
        while (items_offered < goal) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(57, 70) : $urandom_range(0, 12);
            send_message(len, (len > 0) && $urandom_range(0, 1));
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (digest_words_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected word %h index %0d last %b",
                                        o_digest_word, o_word_index, o_last_word));
            end else begin
                want = digest_words_due.pop_front();
                words_checked++;
                if (o_digest_word !== want.word)
                    flag_mismatch($sformatf("digest_word exp %h got %h", want.word, o_digest_word));
                if (o_word_index !== want.idx)
                    flag_mismatch($sformatf("word_index exp %0d got %0d", want.idx, o_word_index));
                if (o_last_word !== want.last)
                    flag_mismatch($sformatf("last_word exp %b got %b", want.last, o_last_word));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_run <= 0;
        end else if (idle_run >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without an item", idle_run);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_data_byte      <= 8'h00;
        i_byte_present   <= 1'b0;
        i_end_of_message <= 1'b0;
        i_out_ready      <= 1'b0;
        hold_go          <= 1'b0;
        restart_hash();

        dir_tab[0]  = {8'hff, 1'b0, 1'b0, 1'b0, 256'h0};
        dir_tab[1]  = {8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST};
        dir_tab[2]  = {8'ha5, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST};
        dir_tab[3]  = {8'h00, 1'b1, 1'b0, 1'b0, 256'h0};
        dir_tab[4]  = {8'hff, 1'b1, 1'b0, 1'b0, 256'h0};
        dir_tab[5]  = {8'h3c, 1'b0, 1'b0, 1'b0, 256'h0};
        dir_tab[6]  = {8'h80, 1'b1, 1'b1, 1'b0, 256'h0};
        dir_tab[7]  = {8'h61, 1'b1, 1'b0, 1'b0, 256'h0};
        dir_tab[8]  = {8'h62, 1'b1, 1'b0, 1'b0, 256'h0};
        dir_tab[9]  = {8'h63, 1'b1, 1'b0, 1'b0, 256'h0};
        dir_tab[10] = {8'h00, 1'b0, 1'b1, 1'b0, 256'h0};
        dir_tab[11] = {8'h7f, 1'b1, 1'b1, 1'b0, 256'h0};
        dir_tab[12] = {8'h01, 1'b1, 1'b0, 1'b0, 256'h0};
        dir_tab[13] = {8'hfe, 1'b1, 1'b0, 1'b0, 256'h0};
        dir_tab[14] = {8'h55, 1'b1, 1'b0, 1'b0, 256'h0};
        dir_tab[15] = {8'haa, 1'b0, 1'b1, 1'b0, 256'h0};

        send_idle = 28;
        recv_idle <= 86;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[r])
            offer_item(dir_tab[r].data, dir_tab[r].present, dir_tab[r].eom,
                       dir_tab[r].pinned, dir_tab[r].digest);

        // A full block whose last byte arrives on the end item.
        send_message(64, 1'b1);
        send_random_until(80);

        send_idle = 86;
        recv_idle <= 28;
        // The pad byte lands at position 56 and forces a second block.
        send_message(56, 1'b0);
        send_random_until(160);

        send_idle = 0;
        recv_idle <= 0;
        hold_go <= 1'b1;
        send_message(55, 1'b1);
        send_random_until(230);

        i_in_valid <= 1'b0;
        while (digest_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items hashed into %0d messages, %0d digest words checked",
                 items_offered, messages_closed, words_checked);
        $display("covered empty and single-block messages, two-block padding, %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/s256_pkg.sv
rtl/core/s256_compress.sv
rtl/core/sha256_message_hash.sv
tb/tb.sv
